/* design/smd_pkg.sv */
// ----------------------------------------------------------------------------
// smd_pkg
// Shared types, codes and key-order helper for the sorted merge with dedup.
// ----------------------------------------------------------------------------
package smd_pkg;

  localparam int RAW_BITS   = 64;
  localparam int FILL_BITS  = 17;
  localparam int MODE_BITS  = 2;
  localparam int WANT_BITS  = 2;
  localparam int INDEX_BITS = 2;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_NEWER     = 2'd0,
    MODE_OLDER     = 2'd1,
    MODE_NEWER_END = 2'd2,
    MODE_OLDER_END = 2'd3
  } smd_mode_t;

  typedef enum logic [WANT_BITS-1:0] {
    WANT_NEWER  = 2'd0,
    WANT_OLDER  = 2'd1,
    WANT_EITHER = 2'd2,
    WANT_NONE   = 2'd3
  } smd_want_t;

  typedef enum logic [INDEX_BITS-1:0] {
    REG_WINDOW_LOW  = 2'd0,
    REG_WINDOW_HIGH = 2'd1,
    REG_TABLE_SIZE  = 2'd2,
    REG_UNUSED      = 2'd3
  } smd_reg_t;

  localparam logic [FILL_BITS-1:0] TABLE_SIZE_RESET = 17'd4096;

  typedef struct packed {
    logic [RAW_BITS-1:0]  window_low;
    logic [RAW_BITS-1:0]  window_high;
    logic [FILL_BITS-1:0] table_cap;
  } smd_cfg_t;

  typedef struct packed {
    smd_mode_t mode;
    logic      in_window;
  } smd_flags_t;

  // big-endian order: byte-reverse the 64-bit pattern
  function automatic logic [RAW_BITS-1:0] key_order(input logic [RAW_BITS-1:0] raw);
    logic [RAW_BITS-1:0] r;
    for (int i = 0; i < RAW_BITS / 8; i++) begin
      r[8*i +: 8] = raw[RAW_BITS-8-8*i +: 8];
    end
    return r;
  endfunction

endpackage

/* design/smd_if.sv */
// ----------------------------------------------------------------------------
// smd_if
// Channel interfaces: input entries, merged results and register writes.
// ----------------------------------------------------------------------------
interface smd_item_if #(
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 64
) ();
  import smd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [MODE_BITS-1:0]  mode;
  logic [KEY_BITS-1:0]   entry_key;
  logic [VALUE_BITS-1:0] entry_value;
  modport source (output valid, mode, entry_key, entry_value, input ready);
  modport sink   (input valid, mode, entry_key, entry_value, output ready);
endinterface

interface smd_result_if #(
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 64
) ();
  import smd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  emit;
  logic [KEY_BITS-1:0]   out_key;
  logic [VALUE_BITS-1:0] out_value;
  logic                  new_table;
  logic [WANT_BITS-1:0]  want_next;
  logic                  finished;
  modport source (output valid, emit, out_key, out_value, new_table, want_next, finished,
                  input ready);
  modport sink   (input valid, emit, out_key, out_value, new_table, want_next, finished,
                  output ready);
endinterface

interface smd_cfg_if ();
  import smd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] index;
  logic [RAW_BITS-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* design/smd_cfg_regs.sv */
// ----------------------------------------------------------------------------
// smd_cfg_regs
// Window bounds and table size registers, written one beat at a time.
// ----------------------------------------------------------------------------
module smd_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_valid,
  input  logic [smd_pkg::INDEX_BITS-1:0] wr_index,
  input  logic [smd_pkg::RAW_BITS-1:0]   wr_data,
  output smd_pkg::smd_cfg_t              cfg_q
);
  import smd_pkg::*;

  logic [FILL_BITS-1:0] size_bits;

  assign size_bits = wr_data[FILL_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.window_low  <= '0;
      cfg_q.window_high <= '1;
      cfg_q.table_cap   <= TABLE_SIZE_RESET;
    end else if (wr_valid) begin
      case (smd_reg_t'(wr_index))
        REG_WINDOW_LOW:  cfg_q.window_low  <= wr_data;
        REG_WINDOW_HIGH: cfg_q.window_high <= wr_data;
        // a size of zero acts as one
        REG_TABLE_SIZE:  cfg_q.table_cap   <= (size_bits == '0) ? FILL_BITS'(1) : size_bits;
        default: ;
      endcase
    end
  end

endmodule

/* design/smd_in_stage.sv */
// ----------------------------------------------------------------------------
// smd_in_stage
// Input register; the window low-bound test on the incoming key is done on the way in.
// ----------------------------------------------------------------------------
module smd_in_stage #(
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  smd_pkg::smd_cfg_t             cfg_q,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [smd_pkg::MODE_BITS-1:0] in_mode,
  input  logic [KEY_BITS-1:0]           in_key,
  input  logic [VALUE_BITS-1:0]         in_value,
  output logic                          st_valid,
  input  logic                          st_ready,
  output smd_pkg::smd_flags_t           st_flags,
  output logic [KEY_BITS-1:0]           st_key,
  output logic [VALUE_BITS-1:0]         st_value
);
  import smd_pkg::*;

  localparam logic [RAW_BITS-1:0] KEY_MASK = {RAW_BITS{1'b1}} >> (RAW_BITS - KEY_BITS);

  logic [RAW_BITS-1:0] key_ord;
  logic [RAW_BITS-1:0] low_ord;
  logic                load;

  assign key_ord  = key_order(RAW_BITS'(in_key));
  assign low_ord  = key_order(cfg_q.window_low & KEY_MASK);
  assign in_ready = !st_valid || st_ready;
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (in_ready) begin
      st_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      st_flags.mode      <= smd_mode_t'(in_mode);
      st_flags.in_window <= key_ord >= low_ord;
      st_key             <= in_key;
      st_value           <= in_value;
    end
  end

endmodule

/* design/smd_merge_core.sv */
// ----------------------------------------------------------------------------
// smd_merge_core
// Head registers, compare-and-select, table counting and the result register.
// ----------------------------------------------------------------------------
module smd_merge_core #(
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  smd_pkg::smd_cfg_t             cfg_q,
  input  logic                          st_valid,
  output logic                          st_ready,
  input  smd_pkg::smd_flags_t           st_flags,
  input  logic [KEY_BITS-1:0]           st_key,
  input  logic [VALUE_BITS-1:0]         st_value,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic                          res_emit,
  output logic [KEY_BITS-1:0]           res_key,
  output logic [VALUE_BITS-1:0]         res_value,
  output logic                          res_new_table,
  output logic [smd_pkg::WANT_BITS-1:0] res_want,
  output logic                          res_finished
);
  import smd_pkg::*;

  localparam logic [RAW_BITS-1:0] KEY_MASK = {RAW_BITS{1'b1}} >> (RAW_BITS - KEY_BITS);

  // head registers
  logic [KEY_BITS-1:0]   n_key, o_key;
  logic [VALUE_BITS-1:0] n_value, o_value;
  logic                  n_full, o_full, n_ended, o_ended;
  logic [FILL_BITS-1:0]  table_fill;
  logic                  stopped;

  logic [KEY_BITS-1:0]   n_key_next, o_key_next;
  logic [VALUE_BITS-1:0] n_value_next, o_value_next;
  logic                  n_full_next, o_full_next, n_ended_next, o_ended_next;
  logic [FILL_BITS-1:0]  table_fill_next;
  logic                  stopped_next;

  logic                  advance, take;
  logic                  load_n, load_o, n_full_l, o_full_l;
  logic [RAW_BITS-1:0]   n_ord, o_ord, high_ord;
  logic                  n_high, o_high;
  logic                  pick_n, pick_o, drop_o, sel_above, do_emit;
  logic                  emit_next, new_table_next, fin_next, need_n, need_o;
  logic [KEY_BITS-1:0]   key_sel;
  logic [VALUE_BITS-1:0] value_sel;
  smd_want_t             want_next;

  assign advance  = !res_valid || res_ready;
  assign st_ready = advance;
  assign take     = st_valid && advance;

  assign high_ord = key_order(cfg_q.window_high & KEY_MASK);

  always_comb begin
    n_key_next      = n_key;
    n_value_next    = n_value;
    o_key_next      = o_key;
    o_value_next    = o_value;
    n_ended_next    = n_ended;
    o_ended_next    = o_ended;
    table_fill_next = table_fill;
    stopped_next    = stopped;
    load_n          = 1'b0;
    load_o          = 1'b0;
    pick_n          = 1'b0;
    pick_o          = 1'b0;
    drop_o          = 1'b0;
    emit_next       = 1'b0;
    new_table_next  = 1'b0;

    if (!stopped) begin
      case (st_flags.mode)
        MODE_NEWER:     load_n = !n_ended && !n_full && st_flags.in_window;
        MODE_OLDER:     load_o = !o_ended && !o_full && st_flags.in_window;
        MODE_NEWER_END: n_ended_next = 1'b1;
        MODE_OLDER_END: o_ended_next = 1'b1;
        default: ;
      endcase
    end
    if (load_n) begin
      n_key_next   = st_key;
      n_value_next = st_value;
    end
    if (load_o) begin
      o_key_next   = st_key;
      o_value_next = st_value;
    end
    n_full_l = n_full || load_n;
    o_full_l = o_full || load_o;
    n_ord    = key_order(RAW_BITS'(n_key_next));
    o_ord    = key_order(RAW_BITS'(o_key_next));
    n_high   = n_ord > high_ord;
    o_high   = o_ord > high_ord;

    if (!stopped) begin
      if (n_full_l && o_full_l) begin
        pick_n = n_ord <= o_ord;
        pick_o = n_ord > o_ord;
        drop_o = n_ord == o_ord;
      end else if (n_full_l && o_ended_next) begin
        pick_n = 1'b1;
      end else if (o_full_l && n_ended_next) begin
        pick_o = 1'b1;
      end
    end

    n_full_next = n_full_l && !pick_n;
    o_full_next = o_full_l && !pick_o && !drop_o;
    sel_above   = pick_o ? o_high : n_high;
    key_sel     = pick_o ? o_key_next : n_key_next;
    value_sel   = pick_o ? o_value_next : n_value_next;
    do_emit     = (pick_n || pick_o) && !sel_above;

    if ((pick_n || pick_o) && sel_above) begin
      stopped_next = 1'b1;
    end
    if (do_emit) begin
      emit_next = 1'b1;
      if (table_fill == '0 || table_fill >= cfg_q.table_cap) begin
        new_table_next  = 1'b1;
        table_fill_next = FILL_BITS'(1);
      end else begin
        table_fill_next = table_fill + FILL_BITS'(1);
      end
    end

    fin_next = stopped_next || (n_ended_next && o_ended_next && !n_full_next && !o_full_next);
    need_n   = !n_full_next && !n_ended_next;
    need_o   = !o_full_next && !o_ended_next;
    if (fin_next) begin
      want_next = WANT_NONE;
    end else if (need_n && need_o) begin
      want_next = WANT_EITHER;
    end else if (need_n) begin
      want_next = WANT_NEWER;
    end else if (need_o) begin
      want_next = WANT_OLDER;
    end else begin
      want_next = WANT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n_full     <= 1'b0;
      o_full     <= 1'b0;
      n_ended    <= 1'b0;
      o_ended    <= 1'b0;
      table_fill <= '0;
      stopped    <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (advance) begin
        res_valid <= st_valid;
      end
      if (take) begin
        n_full     <= n_full_next;
        o_full     <= o_full_next;
        n_ended    <= n_ended_next;
        o_ended    <= o_ended_next;
        table_fill <= table_fill_next;
        stopped    <= stopped_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      n_key         <= n_key_next;
      n_value       <= n_value_next;
      o_key         <= o_key_next;
      o_value       <= o_value_next;
      res_emit      <= emit_next;
      res_key       <= do_emit ? key_sel : '0;
      res_value     <= do_emit ? value_sel : '0;
      res_new_table <= new_table_next;
      res_want      <= want_next;
      res_finished  <= fin_next;
    end
  end

endmodule

/* design/sorted_merge_dedup_window.sv */
// ----------------------------------------------------------------------------
// sorted_merge_dedup_window
// Two-way merge of a newer and an older sorted key/value stream with
// duplicate removal, key window and output table grouping.
// ----------------------------------------------------------------------------
//   channel   dir   beat carries
//   item      in    mode, entry_key, entry_value
//   result    out   emit, out_key, out_value, new_table, want_next, finished
//   cfg       in    index, data (register write)
//
// one item per cycle while the result is taken; the item passes the input register, then the result register
// the input register and the head compare/select feed one result register
// a stalled result holds the merge and then the input register
// synchronous reset clears heads, end marks, table count and stop; no clearing pass
// ----------------------------------------------------------------------------
module sorted_merge_dedup_window #(
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 64
) (
  input logic          clk,
  input logic          rst,
  smd_item_if.sink     item,
  smd_result_if.source result,
  smd_cfg_if.sink      cfg
);
  import smd_pkg::*;

  smd_cfg_t              cfg_q;
  logic                  st_valid, st_ready;
  smd_flags_t            st_flags;
  logic [KEY_BITS-1:0]   st_key;
  logic [VALUE_BITS-1:0] st_value;

  assign cfg.ready = 1'b1;

  smd_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg_q    (cfg_q)
  );

  smd_in_stage #(
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_in (
    .clk      (clk),
    .rst      (rst),
    .cfg_q    (cfg_q),
    .in_valid (item.valid),
    .in_ready (item.ready),
    .in_mode  (item.mode),
    .in_key   (item.entry_key),
    .in_value (item.entry_value),
    .st_valid (st_valid),
    .st_ready (st_ready),
    .st_flags (st_flags),
    .st_key   (st_key),
    .st_value (st_value)
  );

  smd_merge_core #(
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg_q         (cfg_q),
    .st_valid      (st_valid),
    .st_ready      (st_ready),
    .st_flags      (st_flags),
    .st_key        (st_key),
    .st_value      (st_value),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .res_emit      (result.emit),
    .res_key       (result.out_key),
    .res_value     (result.out_value),
    .res_new_table (result.new_table),
    .res_want      (result.want_next),
    .res_finished  (result.finished)
  );

  a_ready_when_out_free : assert property (@(posedge clk) disable iff (rst)
    !result.valid |-> item.ready)
    else $error("input stalled with no result pending");

  a_finished_sticky : assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.ready && result.finished) |=> (!result.valid || result.finished))
    else $error("finished dropped before reset");

  a_finished_wants_none : assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.finished) |-> (result.want_next == WANT_NONE))
    else $error("finished result still asks for a stream");

  a_idle_beat_clean : assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.emit) |-> (!result.new_table && result.out_key == '0))
    else $error("non-emitting result carries an entry");

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-way sorted merge with dedup. A local
// predictor tracks both stream heads, the key window and the table count,
// and every result beat is compared with the oldest prediction. Directed
// sequences cover dedup, full heads, window skips and stream end; random
// phases feed well-formed sorted streams with noise under bursty traffic.
// ----------------------------------------------------------------------------
module tb;
  import smd_pkg::*;

  localparam int KEY_BITS      = 64;
  localparam int VALUE_BITS    = 64;
  localparam int RESET_CYCLES  = 8;
  localparam int SETTLE_CYCLES = 6;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 120;
  localparam logic [63:0] ALL_ONES = '1;

  typedef enum logic [1:0] {
    TAKE_NONE,
    TAKE_NEWER,
    TAKE_OLDER,
    TAKE_BOTH
  } take_t;

  typedef struct packed {
    logic        emit;
    logic [63:0] out_key;
    logic [63:0] out_value;
    logic        new_table;
    smd_want_t   want_next;
    logic        finished;
  } merge_res_t;

  logic clk = 1'b0;
  logic rst;

  smd_item_if #(.KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) item_ch ();
  smd_result_if #(.KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) result_ch ();
  smd_cfg_if cfg_ch ();

  sorted_merge_dedup_window #(
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always #6 clk = ~clk;

  // predictor copy of the block
  logic [63:0] lo_bound, hi_bound;
  logic [16:0] table_cap;
  logic [63:0] nh_key, nh_val, oh_key, oh_val;
  logic        nh_full, oh_full, n_done, o_done, halted;
  logic [16:0] fill_count;
  smd_want_t   cur_want;

  merge_res_t  merged_expect_q [$];
  int          err_count;
  int          cycle_count;
  int          burst_left;
  logic [63:0] n_cur, o_cur;

  function automatic logic [63:0] be_order(input logic [63:0] k);
    return {k[7:0], k[15:8], k[23:16], k[31:24], k[39:32], k[47:40], k[55:48], k[63:56]};
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic merge_res_t merge_predict(input smd_mode_t m, input logic [63:0] k,
                                               input logic [63:0] v);
    merge_res_t  r;
    take_t       take;
    logic [63:0] sel_key, sel_val;
    logic [16:0] cap;
    logic        need_n, need_o;
    r    = '0;
    take = TAKE_NONE;
    if (!halted) begin
      case (m)
        MODE_NEWER: begin
          if (!n_done && !nh_full && be_order(k) >= be_order(lo_bound)) begin
            nh_key  = k;
            nh_val  = v;
            nh_full = 1'b1;
          end
        end
        MODE_OLDER: begin
          if (!o_done && !oh_full && be_order(k) >= be_order(lo_bound)) begin
            oh_key  = k;
            oh_val  = v;
            oh_full = 1'b1;
          end
        end
        MODE_NEWER_END: n_done = 1'b1;
        default: o_done = 1'b1;
      endcase
      if (nh_full && oh_full) begin
        if (be_order(nh_key) < be_order(oh_key)) take = TAKE_NEWER;
        else if (be_order(nh_key) > be_order(oh_key)) take = TAKE_OLDER;
        else take = TAKE_BOTH;
      end else if (nh_full && o_done) begin
        take = TAKE_NEWER;
      end else if (oh_full && n_done) begin
        take = TAKE_OLDER;
      end
      if (take != TAKE_NONE) begin
        if (take == TAKE_OLDER) begin
          sel_key = oh_key;
          sel_val = oh_val;
          oh_full = 1'b0;
        end else begin
          sel_key = nh_key;
          sel_val = nh_val;
          nh_full = 1'b0;
          if (take == TAKE_BOTH) oh_full = 1'b0;
        end
        if (be_order(sel_key) > be_order(hi_bound)) begin
          halted = 1'b1;
        end else begin
          cap         = (table_cap == '0) ? 17'd1 : table_cap;
          r.emit      = 1'b1;
          r.out_key   = sel_key;
          r.out_value = sel_val;
          if (fill_count == '0 || fill_count >= cap) begin
            r.new_table = 1'b1;
            fill_count  = 17'd1;
          end else begin
            fill_count = fill_count + 17'd1;
          end
        end
      end
    end
    r.finished = halted || (n_done && o_done && !nh_full && !oh_full);
    need_n = !nh_full && !n_done;
    need_o = !oh_full && !o_done;
    if (r.finished) r.want_next = WANT_NONE;
    else if (need_n && need_o) r.want_next = WANT_EITHER;
    else if (need_n) r.want_next = WANT_NEWER;
    else if (need_o) r.want_next = WANT_OLDER;
    else r.want_next = WANT_NONE;
    cur_want = r.want_next;
    return r;
  endfunction

  task automatic flag_error(input string msg);
    $display("ERROR @%0d: %s", cycle_count, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) flag_error($sformatf("%s got %h expected %h", name, got, want));
  endtask

  // one item beat, with burst/gap pacing on the sender side
  task automatic send_entry(input smd_mode_t m, input logic [63:0] k, input logic [63:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    item_ch.valid       <= 1'b1;
    item_ch.mode        <= m;
    item_ch.entry_key   <= k;
    item_ch.entry_value <= v;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
    merged_expect_q.push_back(merge_predict(m, k, v));
    burst_left--;
  endtask

  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    while (merged_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [63:0] lo, input logic [63:0] hi,
                           input logic [16:0] cap, input bit spare);
    smd_reg_t    regs [4];
    logic [63:0] vals [4];
    int          n;
    regs[0] = REG_WINDOW_LOW;
    regs[1] = REG_WINDOW_HIGH;
    regs[2] = REG_TABLE_SIZE;
    regs[3] = REG_UNUSED;
    vals[0] = lo;
    vals[1] = hi;
    vals[2] = {47'd0, cap};
    vals[3] = rand64();
    n = spare ? 4 : 3;
    for (int i = 0; i < n; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= regs[i];
      cfg_ch.data  <= vals[i];
      do @(posedge clk); while (cfg_ch.ready !== 1'b1);
      case (regs[i])
        REG_WINDOW_LOW:  lo_bound  = vals[i];
        REG_WINDOW_HIGH: hi_bound  = vals[i];
        REG_TABLE_SIZE:  table_cap = vals[i][16:0];
        default: ;
      endcase
    end
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic feed_stream(input bit to_older);
    logic [63:0] ord;
    if (to_older) begin
      o_cur = o_cur + $urandom_range(0, 2);
      ord   = o_cur;
      send_entry(MODE_OLDER, be_order(ord), rand64());
    end else begin
      n_cur = n_cur + $urandom_range(0, 2);
      ord   = n_cur;
      send_entry(MODE_NEWER, be_order(ord), rand64());
    end
  endtask

  task automatic feed_wanted();
    case (cur_want)
      WANT_NEWER: feed_stream(1'b0);
      WANT_OLDER: feed_stream(1'b1);
      default: feed_stream(bit'($urandom_range(1)));
    endcase
  endtask

  task automatic send_random_entry();
    send_entry($urandom_range(1) ? MODE_OLDER : MODE_NEWER, rand64(), rand64());
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_merge_basics();
    configure(64'd0, ALL_ONES, 17'd2, 1'b1);
    send_entry(MODE_NEWER, 64'd0, ALL_ONES);
    send_entry(MODE_NEWER, rand64(), rand64());          // head full
    send_entry(MODE_OLDER, 64'd0, 64'd0);                // equal keys
    send_entry(MODE_OLDER, be_order(64'd2), rand64());
    send_entry(MODE_NEWER, be_order(64'd1), rand64());
    send_entry(MODE_NEWER, be_order(64'd3), rand64());
    send_entry(MODE_OLDER, be_order(64'd3), rand64());
    // unsorted input
    send_entry(MODE_NEWER, be_order(64'h10), rand64());
    send_entry(MODE_OLDER, be_order(64'h8), rand64());
    send_entry(MODE_OLDER, be_order(64'h1), rand64());
    send_entry(MODE_OLDER, be_order(64'h20), rand64());
    send_entry(MODE_NEWER, ALL_ONES, 64'd0);
    send_entry(MODE_OLDER, ALL_ONES, ALL_ONES);
    wait_drained();
  endtask

  task automatic test_window_low();
    configure(be_order(64'h100), ALL_ONES, 17'd3, 1'b0);
    send_entry(MODE_NEWER, be_order(64'hff), rand64());  // below window
    send_entry(MODE_NEWER, be_order(64'h100), rand64());
    send_entry(MODE_OLDER, be_order(64'h50), rand64());
    send_entry(MODE_OLDER, be_order(64'h200), rand64());
    wait_drained();
    configure(ALL_ONES, ALL_ONES, 17'd1, 1'b0);
    send_entry(MODE_NEWER, rand64() & ~64'h1, rand64());
    send_entry(MODE_NEWER, ALL_ONES, rand64());
    send_entry(MODE_OLDER, ALL_ONES, rand64());
    send_entry(MODE_OLDER, rand64() & ~64'h100, rand64());
    wait_drained();
  endtask

  task automatic test_random_merge();
    logic [63:0] base, lo, lo_ord;
    logic [16:0] cap;
    int          sel;
    for (int p = 0; p < PHASES; p++) begin
      base = rand64() >> 1;
      case (p)
        0: cap = 17'd1;
        1: cap = 17'd0;
        2: cap = 17'd2;
        3: cap = 17'($urandom_range(3, 17));
        4: cap = TABLE_SIZE_RESET;
        5: cap = 17'd65536;
        6: cap = 17'($urandom_range(1, 65536));
        default: cap = 17'($urandom_range(5, 40));
      endcase
      lo = (p % 2 == 0) ? 64'd0 : be_order(base + $urandom_range(0, 20));
      wait_drained();
      configure(lo, ALL_ONES, cap, 1'b0);
      n_cur  = base;
      o_cur  = base;
      lo_ord = be_order(lo_bound);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 0 && i == PHASE_ITEMS / 2) wait_drained();
        sel = $urandom_range(99);
        if (sel < 78) begin
          feed_wanted();
        end else if (sel < 88) begin
          send_random_entry();
        end else if (sel < 95 && lo_ord > 64'd8) begin
          send_entry($urandom_range(1) ? MODE_OLDER : MODE_NEWER,
                     be_order(lo_ord - 64'd1 - $urandom_range(0, 6)), rand64());
        end else if (nh_full) begin
          send_entry(MODE_NEWER, rand64(), rand64());
        end else if (oh_full) begin
          send_entry(MODE_OLDER, rand64(), rand64());
        end else begin
          feed_wanted();
        end
      end
    end
    wait_drained();
  endtask

  task automatic test_stream_end();
    logic [63:0] hi;
    configure(64'd0, ALL_ONES, 17'($urandom_range(1, 8)), 1'b0);
    n_cur = rand64() >> 1;
    o_cur = n_cur;
    for (int i = 0; i < 50 && !nh_full; i++) feed_wanted();
    // newer stream ends with its head still held
    send_entry(MODE_NEWER_END, rand64(), rand64());
    send_entry(MODE_NEWER_END, rand64(), rand64());
    repeat (3) send_entry(MODE_NEWER, rand64(), rand64());
    repeat (10) feed_stream(1'b1);
    if ($urandom_range(1)) begin
      // window passed
      wait_drained();
      hi = $urandom_range(1) ? 64'd0 : be_order(o_cur + 64'd4);
      configure(64'd0, hi, 17'($urandom_range(1, 8)), 1'b0);
      for (int i = 0; i < 100 && !halted; i++) feed_stream(1'b1);
    end else begin
      send_entry(MODE_OLDER_END, rand64(), rand64());
      send_entry(MODE_OLDER_END, rand64(), rand64());
    end
    // everything after finish is ignored
    repeat (6) send_entry(smd_mode_t'($urandom_range(3)), rand64(), rand64());
    wait_drained();
    configure(rand64(), 64'd0, 17'($urandom_range(1, 65536)), 1'b0);
    repeat (4) send_entry(smd_mode_t'($urandom_range(3)), rand64(), rand64());
    wait_drained();
  endtask

  // ---------------------------------------------------------------- processes

  // result beat checking and receiver stall pattern
  initial begin : result_side
    merge_res_t want_r;
    int         rx_run;
    int         rx_kind;
    rx_run  = 0;
    rx_kind = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
        if (merged_expect_q.size() == 0) begin
          flag_error("result beat with nothing expected");
        end else begin
          want_r = merged_expect_q.pop_front();
          check_field("emit", result_ch.emit, want_r.emit);
          check_field("out_key", result_ch.out_key, want_r.out_key);
          check_field("out_value", result_ch.out_value, want_r.out_value);
          check_field("new_table", result_ch.new_table, want_r.new_table);
          check_field("want_next", result_ch.want_next, want_r.want_next);
          check_field("finished", result_ch.finished, want_r.finished);
        end
      end
      if (rx_run == 0) begin
        rx_kind = $urandom_range(2);
        rx_run  = (rx_kind == 0) ? $urandom_range(1, 40) :
                  (rx_kind == 1) ? $urandom_range(1, 6) : $urandom_range(2, 12);
      end
      rx_run--;
      case (rx_kind)
        0: result_ch.ready <= 1'b1;
        1: result_ch.ready <= 1'b0;
        default: result_ch.ready <= ~result_ch.ready;
      endcase
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin : main
    err_count   = 0;
    burst_left  = 0;
    lo_bound    = '0;
    hi_bound    = ALL_ONES;
    table_cap   = TABLE_SIZE_RESET;
    nh_key      = '0;
    nh_val      = '0;
    oh_key      = '0;
    oh_val      = '0;
    nh_full     = 1'b0;
    oh_full     = 1'b0;
    n_done      = 1'b0;
    o_done      = 1'b0;
    halted      = 1'b0;
    fill_count  = '0;
    cur_want    = WANT_EITHER;
    n_cur       = '0;
    o_cur       = '0;
    rst                 <= 1'b1;
    item_ch.valid       <= 1'b0;
    item_ch.mode        <= MODE_NEWER;
    item_ch.entry_key   <= '0;
    item_ch.entry_value <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= REG_WINDOW_LOW;
    cfg_ch.data         <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_merge_basics();
    test_window_low();
    test_random_merge();
    test_stream_end();

    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* sorted_merge_dedup_window.f */
design/smd_pkg.sv
design/smd_if.sv
design/smd_cfg_regs.sv
design/smd_in_stage.sv
design/smd_merge_core.sv
design/sorted_merge_dedup_window.sv
tb/tb.sv
